/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, alphabet constants and the character classifier for the
// streaming base64 / base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // alphabet offsets
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;

    // results one character can cause at most
    localparam int unsigned MAX_ITEMS = 4;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_PAD   = 2'd1,
        K_SPACE = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] val;
    } t_class;

    // input beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       string_ok;
        logic       run_last;
    } t_out_beat;

    // one queued result, run_last is added on the way out
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       string_ok;
    } t_res_item;

    // all results caused by one character
    typedef struct packed {
        logic [2:0]                     cnt;
        t_res_item [MAX_ITEMS-1:0]      item;
    } t_bundle;

    // map a character to its class and sextet value
    function automatic t_class b64d_classify(input logic [7:0] c);
        t_class r;
        r.kind = K_BAD;
        r.val  = 6'd0;
        if (c >= "A" && c <= "Z") begin
            r.kind = K_DATA;
            r.val  = 6'(c - 8'h41);
        end else if (c >= "a" && c <= "z") begin
            r.kind = K_DATA;
            r.val  = 6'(c - 8'h61) + LOWER_BASE;
        end else if (c >= "0" && c <= "9") begin
            r.kind = K_DATA;
            r.val  = 6'(c - 8'h30) + DIGIT_BASE;
        end else if (c == "-" || c == "+") begin
            r.kind = K_DATA;
            r.val  = VAL_PLUS;
        end else if (c == "_" || c == "/") begin
            r.kind = K_DATA;
            r.val  = VAL_SLASH;
        end else if (c == "=") begin
            r.kind = K_PAD;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
            r.kind = K_SPACE;
        end
        return r;
    endfunction

endpackage

/* rtl/b64d_decode.sv */
// ----------------------------------------------------------------------------
// b64d_decode
// Input register, group state and per-character result bundle. Each
// registered character is classified, folded into the open group and turned
// into a bundle of up to four results in a single pass.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  b64d_pkg::t_in_beat i_data,
    output logic              o_bnd_valid,
    input  logic              i_bnd_take,
    output b64d_pkg::t_bundle o_bnd
);
    import b64d_pkg::*;

    logic            r_in_valid;
    t_in_beat        r_in;
    logic [5:0]      r_store [3];
    logic [1:0]      r_pos;
    logic [1:0]      r_pad;
    logic            r_err;

    logic [5:0]      n_store [3];
    logic [1:0]      n_pos;
    logic [1:0]      n_pad;
    logic            n_err;

    t_class          cls;
    logic [1:0]      pad_g;
    logic            close;
    logic            adv;
    logic            fin_err;
    logic [7:0]      byt [3];
    logic [2:0]      ena;
    logic [2:0]      nb;

    assign adv     = r_in_valid & i_bnd_take;
    assign o_ready = ~r_in_valid | adv;
    assign o_bnd_valid = r_in_valid;

    // fold the character into the open group
    always_comb begin
        cls     = b64d_classify(r_in.ch);
        n_store = r_store;
        n_pos   = r_pos;
        n_pad   = r_pad;
        n_err   = r_err;
        pad_g   = r_pad;
        close   = 1'b0;
        case (cls.kind)
            K_BAD: begin
                n_err = 1'b1;
            end
            K_DATA, K_PAD: begin
                if (cls.kind == K_PAD && r_pad < 2'd2) begin
                    pad_g = r_pad + 2'd1;
                end
                if (r_pos == 2'd3) begin
                    close = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        n_store[i] = 6'd0;
                    end
                    n_pos = 2'd0;
                    n_pad = 2'd0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_pos == 2'(i)) begin
                            n_store[i] = cls.val;
                        end
                    end
                    n_pos = r_pos + 2'd1;
                    n_pad = pad_g;
                end
            end
            default: ;
        endcase
    end

    // data bytes: a closed group or the partial group at end of string
    always_comb begin
        fin_err = n_err | (r_in.last & (n_pos == 2'd1));
        if (close) begin
            byt[0] = {r_store[0], r_store[1][5:4]};
            byt[1] = {r_store[1][3:0], r_store[2][5:2]};
            byt[2] = {r_store[2][1:0], cls.val};
            ena[0] = ~r_err;
            ena[1] = ~r_err & (pad_g < 2'd2);
            ena[2] = ~r_err & (pad_g < 2'd1);
        end else begin
            byt[0] = {n_store[0], n_store[1][5:4]};
            byt[1] = {n_store[1][3:0], n_store[2][5:2]};
            byt[2] = 8'd0;
            ena[0] = r_in.last & (n_pos >= 2'd2) & ~n_err;
            ena[1] = ena[0] & (n_pos == 2'd3) & (n_pad < 2'd2);
            ena[2] = 1'b0;
        end
        nb = 3'(ena[0]) + 3'(ena[1]) + 3'(ena[2]);
    end

    // bundle: bytes first, status item after them on the last character
    always_comb begin
        o_bnd.cnt = nb + 3'(r_in.last);
        for (int i = 0; i < MAX_ITEMS; i++) begin
            o_bnd.item[i].out_byte      = 8'd0;
            o_bnd.item[i].byte_valid    = 1'b0;
            o_bnd.item[i].end_of_string = 1'b1;
            o_bnd.item[i].string_ok     = ~fin_err;
            if (i < 3 && 3'(i) < nb) begin
                o_bnd.item[i].out_byte      = byt[i % 3];
                o_bnd.item[i].byte_valid    = 1'b1;
                o_bnd.item[i].end_of_string = 1'b0;
                o_bnd.item[i].string_ok     = 1'b0;
            end
        end
    end

    // input register control and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= 2'd0;
            r_pad      <= 2'd0;
            r_err      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_store[i] <= 6'd0;
            end
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                if (r_in.last) begin
                    r_pos <= 2'd0;
                    r_pad <= 2'd0;
                    r_err <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        r_store[i] <= 6'd0;
                    end
                end else begin
                    r_pos   <= n_pos;
                    r_pad   <= n_pad;
                    r_err   <= n_err;
                    r_store <= n_store;
                end
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in <= i_data;
        end
    end

endmodule

/* rtl/b64d_serial.sv */
// ----------------------------------------------------------------------------
// b64d_serial
// Result register: holds one bundle and hands its items out one beat at a
// time, loading the next bundle as the last item leaves.
// ----------------------------------------------------------------------------
module b64d_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_bnd_valid,
    output logic               o_bnd_take,
    input  b64d_pkg::t_bundle  i_bnd,
    output logic               o_valid,
    input  logic               i_ready,
    output b64d_pkg::t_out_beat o_data
);
    import b64d_pkg::*;

    logic [2:0]                r_cnt;
    t_res_item [MAX_ITEMS-1:0] r_item;
    logic                      out_acc;
    logic                      load;

    assign o_valid    = (r_cnt != 3'd0);
    assign out_acc    = o_valid & i_ready;
    assign o_bnd_take = (r_cnt == 3'd0) | ((r_cnt == 3'd1) & out_acc);
    assign load       = i_bnd_valid & o_bnd_take;

    // head item out, flag the last one of the bundle
    always_comb begin
        o_data.out_byte      = r_item[0].out_byte;
        o_data.byte_valid    = r_item[0].byte_valid;
        o_data.end_of_string = r_item[0].end_of_string;
        o_data.string_ok     = r_item[0].string_ok;
        o_data.run_last      = (r_cnt == 3'd1);
    end

    // item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (load) begin
            r_cnt <= i_bnd.cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // item queue, shifts towards the head
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_bnd.item;
        end else if (out_acc) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                r_item[i] <= r_item[i+1];
            end
        end
    end

endmodule

/* rtl/base64url_decoder_core.sv */
// ----------------------------------------------------------------------------
// base64url_decoder_core
// Streaming base64 decoder for the URL-safe and standard alphabets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_data): one character per beat, with
//   last marking the final character of a string. Whitespace is skipped,
//   '=' takes a padding position, invalid characters set a sticky error.
//   Output channel (o_valid / i_ready / o_data): decoded bytes, then one
//   status beat per string (end_of_string = 1, string_ok = no error seen).
//   run_last marks the final beat caused by one character.
//   The first result of a character passes the input register, then the
//   result register, on its way to the output.
//   Throughput: one character per cycle while each causes at most one
//   result and the receiver is ready; a character that closes a group or
//   ends a string holds until the single-beat output register drains it.
//   When the receiver stalls, the result register holds and the input
//   register fills; o_ready drops once both are occupied.
//   Reset clears the group state, the error flag and both valid flags.
// ----------------------------------------------------------------------------
module base64url_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64d_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output b64d_pkg::t_out_beat o_data
);
    import b64d_pkg::*;

    logic    bnd_valid;
    logic    bnd_take;
    t_bundle bnd;

    // classify and fold into the group
    b64d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_bnd_valid (bnd_valid),
        .i_bnd_take  (bnd_take),
        .o_bnd       (bnd)
    );

    // hand out results one beat at a time
    b64d_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bnd_valid (bnd_valid),
        .o_bnd_take  (bnd_take),
        .i_bnd       (bnd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64url_decoder_core. A queue of characters is
// fed through a valid/ready driver; every accepted character is decoded by a
// local model of the decoder and the beats it should cause are queued. A
// monitor compares every output beat, field by field, with the oldest queued
// beat. The run covers directed corner strings, then random token-like
// strings, broken strings and noise under four idling mixes, with one long
// receiver hold-off to back the decoder up.
// ----------------------------------------------------------------------------
module tb;

    import b64d_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int CHARS_PER_MIX = 95;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_LEN      = 150;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_beat    i_data  = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_beat   o_data;

    // decoder model state
    logic [5:0]  grp_sextet [3] = '{default: 6'd0};
    logic [1:0]  grp_pos  = 2'd0;
    logic [1:0]  grp_pads = 2'd0;
    logic        str_err  = 1'b0;

    t_in_beat    char_q[$];
    t_out_beat   decoded_q[$];
    int          pushed_cnt    = 0;
    int          counted_cnt   = 0;
    int          acc_cnt       = 0;
    int          fault_cnt     = 0;
    int          cyc_cnt       = 0;
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int          hold_cnt      = 0;
    logic        hold_done     = 1'b0;

    base64url_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #10 i_clk = ~i_clk;

    // character class and sextet value
    function automatic t_kind char_kind(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41);
            return K_DATA;
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd26);
            return K_DATA;
        end
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
            return K_DATA;
        end
        if (c == "-" || c == "+") begin
            v = 6'd62;
            return K_DATA;
        end
        if (c == "_" || c == "/") begin
            v = 6'd63;
            return K_DATA;
        end
        if (c == "=") return K_PAD;
        if (c == " " || c == "\t" || c == "\r" || c == "\n") return K_SPACE;
        return K_BAD;
    endfunction

    function automatic t_out_beat data_beat(input logic [7:0] b);
        t_out_beat r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic string fmt_beat(input t_out_beat b);
        return $sformatf("byte=%02h bv=%0b eos=%0b ok=%0b rl=%0b", b.out_byte,
                         b.byte_valid, b.end_of_string, b.string_ok, b.run_last);
    endfunction

    // work out the beats one accepted character causes
    task automatic decode_char(input t_in_beat beat);
        t_kind      kind;
        logic [5:0] val;
        t_out_beat  outs[$];
        t_out_beat  status;
        kind = char_kind(beat.ch, val);
        if (kind == K_BAD) begin
            str_err = 1'b1;
        end else if (kind != K_SPACE) begin
            if (kind == K_PAD && grp_pads < 2'd2) grp_pads++;
            if (grp_pos == 2'd3) begin
                // fourth position closes the group
                if (!str_err) begin
                    outs.push_back(data_beat({grp_sextet[0], grp_sextet[1][5:4]}));
                    if (grp_pads < 2'd2)
                        outs.push_back(data_beat({grp_sextet[1][3:0], grp_sextet[2][5:2]}));
                    if (grp_pads < 2'd1)
                        outs.push_back(data_beat({grp_sextet[2][1:0], val}));
                end
                grp_sextet = '{default: 6'd0};
                grp_pos    = 2'd0;
                grp_pads   = 2'd0;
            end else begin
                grp_sextet[grp_pos] = val;
                grp_pos++;
            end
        end
        // end of string flushes a partial group and adds the status beat
        if (beat.last) begin
            if (grp_pos == 2'd1) begin
                str_err = 1'b1;
            end else if (grp_pos >= 2'd2 && !str_err) begin
                outs.push_back(data_beat({grp_sextet[0], grp_sextet[1][5:4]}));
                if (grp_pos == 2'd3 && grp_pads < 2'd2)
                    outs.push_back(data_beat({grp_sextet[1][3:0], grp_sextet[2][5:2]}));
            end
            status               = '0;
            status.end_of_string = 1'b1;
            status.string_ok     = ~str_err;
            outs.push_back(status);
            grp_sextet = '{default: 6'd0};
            grp_pos    = 2'd0;
            grp_pads   = 2'd0;
            str_err    = 1'b0;
        end
        if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
        foreach (outs[i]) decoded_q.push_back(outs[i]);
    endtask

    // queue one character for the driver
    task automatic push_char(input logic [7:0] c, input logic last);
        t_in_beat   b;
        logic [5:0] v;
        b.ch   = c;
        b.last = last;
        char_q.push_back(b);
        pushed_cnt++;
        if (last || char_kind(c, v) != K_SPACE) counted_cnt++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0:       return " ";
            1:       return "\t";
            2:       return "\r";
            default: return "\n";
        endcase
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input bit url);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
        if (v == 6'd62) return url ? "-" : "+";
        return url ? "_" : "/";
    endfunction

    // token-like string with random content; broken ones may end on a
    // single position or carry an invalid character
    task automatic gen_string(input bit broken);
        logic [7:0] txt[$];
        logic [7:0] c;
        logic [5:0] v;
        int         grps;
        int         tail;
        int         tail_len;
        bit         url;
        bit         trail;
        url  = 1'($urandom_range(0, 1));
        grps = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        tail = broken ? $urandom_range(0, 3) : $urandom_range(0, 2);
        case (tail)
            1:       tail_len = 2;
            2:       tail_len = 3;
            3:       tail_len = 1;
            default: tail_len = 0;
        endcase
        for (int i = 0; i < grps * 4 + tail_len; i++)
            txt.push_back(sextet_char(6'($urandom_range(0, 63)), url));
        // padding to a full group, or trailing pads in a closed group
        if (tail == 1 && $urandom_range(0, 1) == 1) begin
            txt.push_back("=");
            txt.push_back("=");
        end else if (tail == 2 && $urandom_range(0, 1) == 1) begin
            txt.push_back("=");
        end else if (tail == 0 && grps > 0 && $urandom_range(0, 3) == 0) begin
            txt[txt.size() - 1] = "=";
            if ($urandom_range(0, 1) == 1) txt[txt.size() - 2] = "=";
        end
        // padding at a random position, possibly ahead of data
        if (txt.size() > 0 && $urandom_range(0, 7) == 0)
            txt[$urandom_range(0, txt.size() - 1)] = "=";
        if (broken && $urandom_range(0, 1) == 1) begin
            do c = 8'($urandom_range(0, 255)); while (char_kind(c, v) != K_BAD);
            txt.insert($urandom_range(0, txt.size()), c);
        end
        if (txt.size() == 0) begin
            push_char(ws_char(), 1'b1);
        end else begin
            trail = ($urandom_range(0, 5) == 0);
            foreach (txt[i]) begin
                if ($urandom_range(0, 9) == 0) push_char(ws_char(), 1'b0);
                push_char(txt[i], !trail && i == txt.size() - 1);
            end
            if (trail) push_char(ws_char(), 1'b1);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_char(i_data);
                acc_cnt <= acc_cnt + 1;
            end
            if (!i_valid || o_ready) begin
                if (char_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data  <= char_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && acc_cnt == HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (decoded_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unexpected beat: %s", fmt_beat(o_data));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_data.out_byte !== want.out_byte
                        || o_data.byte_valid !== want.byte_valid
                        || o_data.end_of_string !== want.end_of_string
                        || o_data.string_ok !== want.string_ok
                        || o_data.run_last !== want.run_last) begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display("mismatch: expected %s, got %s",
                                     fmt_beat(want), fmt_beat(o_data));
                    end
                end
            end
            i_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial begin
        int mark;
        int n;
        bit tail_last;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 82; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 82; end
                default: begin snd_idle_pct = 20; rcv_stall_pct = 20; end
            endcase
            if (mix == 0) begin
                // all-ones sextets, mixed alphabets, whitespace end, empty
                // string, padded tails, partial three, single position,
                // invalid character and padding ahead of data
                push_text("////");
                push_text("Az9-\n");
                push_text(" ");
                push_text("QQ==");
                push_text("QUE");
                push_text("Q");
                push_text("Z\377a0");
                push_text("=a0Z");
            end
            mark = counted_cnt;
            while (counted_cnt - mark < CHARS_PER_MIX) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // noise, possibly left open into the next string
                        n         = $urandom_range(1, 6);
                        tail_last = 1'($urandom_range(0, 1));
                        for (int i = 0; i < n; i++)
                            push_char(8'($urandom_range(0, 255)), tail_last && i == n - 1);
                    end
                    1, 2:    gen_string(1'b1);
                    default: gen_string(1'b0);
                endcase
            end
            while (acc_cnt != pushed_cnt) @(negedge i_clk);
        end
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fault_cnt == 0 && decoded_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
